// ----- design/lfb_pkg.sv -----
// ----------------------------------------------------------------------------
// lfb_pkg: shared types and constants
// Command and result payloads, operation codes and strip constants for the
// LED frame buffer with global brightness.
// ----------------------------------------------------------------------------
package lfb_pkg;

    localparam int PIXEL_COUNT  = 18;
    localparam int IDX_W        = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CHAN_W       = 8;
    localparam int COLOR_W      = 3 * CHAN_W;
    localparam int POS_W        = 5;

    localparam logic [CHAN_W-1:0] BRIGHT_RESET = 8'd10;
    localparam logic [CHAN_W-1:0] BRIGHT_STEP  = 8'd10;
    localparam logic [CHAN_W-1:0] BRIGHT_MAX   = 8'd255;
    localparam logic [CHAN_W-1:0] BRIGHT_MIN   = 8'd2;

    typedef enum logic [1:0] {
        OP_SET_ONE     = 2'd0,
        OP_SET_ALL     = 2'd1,
        OP_BRIGHT_UP   = 2'd2,
        OP_BRIGHT_DOWN = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [POS_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] color_in;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0]   pixel_position;
        logic [COLOR_W-1:0] dim_color;
        logic               last_pixel;
    } t_pix;

endpackage

// ----- design/led_frame_buffer_brightness.sv -----
// ----------------------------------------------------------------------------
// led_frame_buffer_brightness: RGB LED frame buffer with global brightness
// Applies one command per transfer, then streams the whole strip, scaled.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The command is
// applied in the cycle it is taken; the block then reads the pixel store one
// entry per cycle through a single shared scaler and presents each scaled
// pixel on o_result for one cycle with o_strobe high, pixel 0 first and
// last_pixel set on the final one. The last result appears while busy is
// already low. The receiver cannot stall: every strobed result must be
// captured in that cycle.
module led_frame_buffer_brightness (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lfb_pkg::t_cmd i_cmd,
    output logic          o_strobe,
    output lfb_pkg::t_pix o_result
);

    localparam logic [lfb_pkg::IDX_W-1:0] LAST_IDX = lfb_pkg::IDX_W'(lfb_pkg::PIXEL_COUNT - 1);

    lfb_pkg::t_state r_state, n_state;
    logic [lfb_pkg::IDX_W-1:0]   r_pos, n_pos;
    logic [lfb_pkg::CHAN_W-1:0]  r_bright, n_bright;
    logic [lfb_pkg::COLOR_W-1:0] r_store [lfb_pkg::PIXEL_COUNT];
    logic                        r_strobe, n_strobe;
    lfb_pkg::t_pix               r_out, n_out;
    logic [lfb_pkg::COLOR_W-1:0] scaled;
    logic                        accept;
    logic                        idx_ok;
    logic [lfb_pkg::CHAN_W:0]    up_sum;

    assign accept = start && !busy;
    assign busy   = (r_state == lfb_pkg::ST_RUN);
    assign idx_ok = ({1'b0, i_cmd.pixel_index} < (lfb_pkg::POS_W+1)'(lfb_pkg::PIXEL_COUNT));
    assign up_sum = {1'b0, r_bright} + {1'b0, lfb_pkg::BRIGHT_STEP};

    lfb_scale u_scale (
        .i_color  (r_store[r_pos]),
        .i_bright (r_bright),
        .o_color  (scaled)
    );

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_bright = r_bright;
        n_strobe = 1'b0;
        n_out    = r_out;
        case (r_state)
            lfb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lfb_pkg::ST_RUN;
                    n_pos   = '0;
                    case (i_cmd.operation)
                        lfb_pkg::OP_BRIGHT_UP: begin
                            n_bright = (up_sum > {1'b0, lfb_pkg::BRIGHT_MAX}) ?
                                       lfb_pkg::BRIGHT_MAX : up_sum[lfb_pkg::CHAN_W-1:0];
                        end
                        lfb_pkg::OP_BRIGHT_DOWN: begin
                            n_bright = (r_bright < lfb_pkg::BRIGHT_STEP + lfb_pkg::BRIGHT_MIN) ?
                                       lfb_pkg::BRIGHT_MIN : r_bright - lfb_pkg::BRIGHT_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            lfb_pkg::ST_RUN: begin
                n_strobe                = 1'b1;
                n_out.pixel_position    = lfb_pkg::POS_W'(r_pos);
                n_out.dim_color         = scaled;
                n_out.last_pixel        = (r_pos == LAST_IDX);
                if (r_pos == LAST_IDX) begin
                    n_state = lfb_pkg::ST_IDLE;
                end else begin
                    n_pos = r_pos + lfb_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = lfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lfb_pkg::ST_IDLE;
            r_pos    <= '0;
            r_bright <= lfb_pkg::BRIGHT_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_bright <= n_bright;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lfb_pkg::PIXEL_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else if (accept) begin
            if (i_cmd.operation == lfb_pkg::OP_SET_ALL) begin
                for (int i = 0; i < lfb_pkg::PIXEL_COUNT; i++) begin
                    r_store[i] <= i_cmd.color_in;
                end
            end else if (i_cmd.operation == lfb_pkg::OP_SET_ONE && idx_ok) begin
                r_store[i_cmd.pixel_index[lfb_pkg::IDX_W-1:0]] <= i_cmd.color_in;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_strobe_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a running refresh");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_pixel) |-> !busy)
        else $error("refresh still running after last pixel");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && r_pos == '0))
        else $error("accepted command did not start a refresh at pixel 0");

    a_bright_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bright >= lfb_pkg::BRIGHT_MIN)
        else $error("brightness below floor");

endmodule

// ----- design/lfb_scale.sv -----
// ----------------------------------------------------------------------------
// lfb_scale: pixel brightness scaler
// Scales each 8-bit channel of a color as channel*brightness/255, truncated,
// using a multiply and a reciprocal correction for the divide by 255.
// ----------------------------------------------------------------------------
module lfb_scale (
    input  logic [lfb_pkg::COLOR_W-1:0] i_color,
    input  logic [lfb_pkg::CHAN_W-1:0]  i_bright,
    output logic [lfb_pkg::COLOR_W-1:0] o_color
);

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [2*lfb_pkg::CHAN_W-1:0] prod;
        logic [2*lfb_pkg::CHAN_W-1:0] corr;

        always_comb begin
            prod = {{lfb_pkg::CHAN_W{1'b0}}, i_color[c*lfb_pkg::CHAN_W +: lfb_pkg::CHAN_W]} *
                   {{lfb_pkg::CHAN_W{1'b0}}, i_bright};
            // exact x/255 for x <= 255*255
            corr = prod + (prod >> lfb_pkg::CHAN_W) + 16'd1;
        end

        assign o_color[c*lfb_pkg::CHAN_W +: lfb_pkg::CHAN_W] =
            corr[2*lfb_pkg::CHAN_W-1:lfb_pkg::CHAN_W];
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for led_frame_buffer_brightness
// Drives pixel writes and brightness commands, tracks the strip and the
// brightness level alongside the block, and checks every scaled pixel of each
// refresh run against the tracked state.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_PCT     = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * lfb_pkg::PIXEL_COUNT + 4;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    lfb_pkg::t_cmd i_cmd   = '0;
    logic          o_strobe;
    lfb_pkg::t_pix o_result;

    logic [lfb_pkg::COLOR_W-1:0] strip_colors [lfb_pkg::PIXEL_COUNT];
    logic [lfb_pkg::CHAN_W-1:0]  level = lfb_pkg::BRIGHT_RESET;
    lfb_pkg::t_pix               expected_pixels [$];

    int idle_pct       = IDLE_PCT;
    int cmds_sent      = 0;
    int pixels_checked = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    led_frame_buffer_brightness u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    function automatic logic [lfb_pkg::CHAN_W-1:0] scale_chan(
        input logic [lfb_pkg::CHAN_W-1:0] c);
        logic [2*lfb_pkg::CHAN_W-1:0] prod;
        prod = {{lfb_pkg::CHAN_W{1'b0}}, c} * {{lfb_pkg::CHAN_W{1'b0}}, level};
        return lfb_pkg::CHAN_W'(prod / 255);
    endfunction

    function automatic void apply_command(input lfb_pkg::t_cmd c);
        lfb_pkg::t_pix               px;
        logic [lfb_pkg::COLOR_W-1:0] col;
        case (c.operation)
            lfb_pkg::OP_SET_ONE: begin
                if (c.pixel_index < lfb_pkg::PIXEL_COUNT)
                    strip_colors[c.pixel_index] = c.color_in;
            end
            lfb_pkg::OP_SET_ALL: begin
                foreach (strip_colors[i])
                    strip_colors[i] = c.color_in;
            end
            lfb_pkg::OP_BRIGHT_UP: begin
                if (int'(level) + int'(lfb_pkg::BRIGHT_STEP) > int'(lfb_pkg::BRIGHT_MAX))
                    level = lfb_pkg::BRIGHT_MAX;
                else
                    level = level + lfb_pkg::BRIGHT_STEP;
            end
            default: begin
                if (level < lfb_pkg::BRIGHT_STEP + lfb_pkg::BRIGHT_MIN)
                    level = lfb_pkg::BRIGHT_MIN;
                else
                    level = level - lfb_pkg::BRIGHT_STEP;
            end
        endcase
        for (int i = 0; i < lfb_pkg::PIXEL_COUNT; i++) begin
            col = strip_colors[i];
            px.pixel_position = lfb_pkg::POS_W'(i);
            px.dim_color      = {scale_chan(col[2*lfb_pkg::CHAN_W +: lfb_pkg::CHAN_W]),
                                 scale_chan(col[lfb_pkg::CHAN_W +: lfb_pkg::CHAN_W]),
                                 scale_chan(col[0 +: lfb_pkg::CHAN_W])};
            px.last_pixel     = (i == lfb_pkg::PIXEL_COUNT - 1);
            expected_pixels.push_back(px);
        end
    endfunction

    task automatic send_cmd(input lfb_pkg::t_op op, input logic [lfb_pkg::POS_W-1:0] idx,
                            input logic [lfb_pkg::COLOR_W-1:0] color);
        lfb_pkg::t_cmd c;
        bit            offered;
        c.operation   = op;
        c.pixel_index = idx;
        c.color_in    = color;
        do begin
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                start   <= 1'b0;
                offered = 1'b0;
            end else begin
                start   <= 1'b1;
                i_cmd   <= c;
                offered = 1'b1;
            end
            @(posedge i_clk);
        end while (!(offered && busy === 1'b0));
        apply_command(c);
        cmds_sent++;
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [lfb_pkg::COLOR_W-1:0] rand_color();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return lfb_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [lfb_pkg::POS_W-1:0] rand_index();
        if ($urandom_range(3) == 0)
            return lfb_pkg::POS_W'($urandom_range(31, lfb_pkg::PIXEL_COUNT));
        return lfb_pkg::POS_W'($urandom_range(lfb_pkg::PIXEL_COUNT - 1));
    endfunction

    task automatic test_set_one();
        send_cmd(lfb_pkg::OP_SET_ONE, 5'd0, 24'hFFFFFF);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'(lfb_pkg::PIXEL_COUNT - 1), 24'h123456);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'(lfb_pkg::PIXEL_COUNT), 24'hA5A5A5);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'd31, 24'hFFFFFF);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'd9, 24'h000000);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'd10, 24'h80FF01);
    endtask

    task automatic test_set_all();
        send_cmd(lfb_pkg::OP_SET_ALL, 5'd31, 24'hFFFFFF);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'd3, 24'h7F0080);
    endtask

    // unused fields carry junk on the brightness commands
    task automatic test_brightness_edges();
        send_cmd(lfb_pkg::OP_BRIGHT_DOWN, 5'd31, 24'hFFFFFF);
        send_cmd(lfb_pkg::OP_BRIGHT_DOWN, 5'd0, 24'h000000);
        send_cmd(lfb_pkg::OP_BRIGHT_UP, 5'd31, 24'h000000);
        send_cmd(lfb_pkg::OP_BRIGHT_UP, 5'd0, 24'hFFFFFF);
    endtask

    task automatic test_drain_pause();
        repeat (3)
            send_cmd(lfb_pkg::t_op'($urandom_range(3)), rand_index(), rand_color());
        wait_results_done();
        send_cmd(lfb_pkg::OP_SET_ALL, 5'd0, 24'hFF8001);
        send_cmd(lfb_pkg::OP_SET_ONE, 5'd16, 24'h01FE7F);
    endtask

    // no idling here: ceiling, one extra step, floor, one extra step
    task automatic test_brightness_sweep();
        idle_pct = 0;
        while (level != lfb_pkg::BRIGHT_MAX)
            send_cmd(lfb_pkg::OP_BRIGHT_UP, rand_index(), rand_color());
        send_cmd(lfb_pkg::OP_BRIGHT_UP, rand_index(), rand_color());
        while (level != lfb_pkg::BRIGHT_MIN)
            send_cmd(lfb_pkg::OP_BRIGHT_DOWN, rand_index(), rand_color());
        send_cmd(lfb_pkg::OP_BRIGHT_DOWN, rand_index(), rand_color());
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_random(input int n);
        repeat (n)
            send_cmd(lfb_pkg::t_op'($urandom_range(3)), rand_index(), rand_color());
    endtask

    always @(posedge i_clk) begin : check_results
        lfb_pkg::t_pix exp_px;
        if (i_rst_n && o_strobe) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: pos=%0d color=%06h last=%0b", $time,
                         o_result.pixel_position, o_result.dim_color,
                         o_result.last_pixel);
                error_count++;
            end else begin
                exp_px = expected_pixels.pop_front();
                pixels_checked++;
                if (o_result.pixel_position !== exp_px.pixel_position) begin
                    $display("%0t: pixel_position expected %0d got %0d", $time,
                             exp_px.pixel_position, o_result.pixel_position);
                    error_count++;
                end
                if (o_result.dim_color !== exp_px.dim_color) begin
                    $display("%0t: dim_color (pos %0d) expected %06h got %06h", $time,
                             exp_px.pixel_position, exp_px.dim_color,
                             o_result.dim_color);
                    error_count++;
                end
                if (o_result.last_pixel !== exp_px.last_pixel) begin
                    $display("%0t: last_pixel (pos %0d) expected %0b got %0b", $time,
                             exp_px.pixel_position, exp_px.last_pixel,
                             o_result.last_pixel);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (strip_colors[i])
            strip_colors[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_set_one();
        test_set_all();
        test_brightness_edges();
        test_drain_pause();
        test_brightness_sweep();
        test_random(42);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands, checked %0d pixel transfers", cmds_sent, pixels_checked);
        $display("Covered single/full writes, out-of-strip index, brightness floor to cap");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- led_frame_buffer_brightness.f -----
design/lfb_pkg.sv
design/lfb_scale.sv
design/led_frame_buffer_brightness.sv
test/tb_top.sv
